// File: hdl/bse_pkg.sv
`timescale 1ns / 1ps

package bse_pkg;

  // fixed field widths of the channels
  localparam int CMD_W     = 4;
  localparam int SET_IDX_W = 4;
  localparam int BIT_IDX_W = 8;
  localparam int CFG_W     = 9;
  localparam int FOUND_W   = 8;

  // bits_in_use after reset
  localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 9'd256;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_BIT  = 4'd0,
    CMD_CLR_BIT  = 4'd1,
    CMD_UNION    = 4'd2,
    CMD_COPY     = 4'd3,
    CMD_SUBTRACT = 4'd4,
    CMD_EQUAL    = 4'd5,
    CMD_CLR_ALL  = 4'd6,
    CMD_SET_ALL  = 4'd7,
    CMD_FIND     = 4'd8
  } cmd_t;

endpackage

// File: hdl/bse_if.sv
`timescale 1ns / 1ps

// command channel
interface bse_in_if;
  import bse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [SET_IDX_W-1:0] target_set;
  logic [SET_IDX_W-1:0] source_set;
  logic [BIT_IDX_W-1:0] bit_index;

  modport source (output valid, command, target_set, source_set, bit_index, input ready);
  modport sink   (input valid, command, target_set, source_set, bit_index, output ready);
endinterface

// result channel
interface bse_out_if;
  import bse_pkg::*;
  logic               valid;
  logic               ready;
  logic               flag;
  logic [FOUND_W-1:0] found_index;

  modport source (output valid, flag, found_index, input ready);
  modport sink   (input valid, flag, found_index, output ready);
endinterface

// size register write channel
interface bse_cfg_if;
  import bse_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] bits_in_use;

  modport source (output valid, bits_in_use, input ready);
  modport sink   (input valid, bits_in_use, output ready);
endinterface

// File: hdl/bse_ram.sv
`timescale 1ns / 1ps

module bse_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: hdl/bse_word_alu.sv
`timescale 1ns / 1ps

module bse_word_alu #(
  parameter int  WORD_BITS = 64,
  localparam int OW        = $clog2(WORD_BITS + 1),
  localparam int SW        = $clog2(WORD_BITS)
) (
  input  bse_pkg::cmd_t         op,
  input  logic [WORD_BITS-1:0]  t_word,
  input  logic [WORD_BITS-1:0]  s_word,
  input  logic [OW-1:0]         lo_off,
  input  logic [OW-1:0]         hi_off,
  output logic [WORD_BITS-1:0]  wr_word,
  output logic                  words_eq,
  output logic                  hit,
  output logic [SW-1:0]         hit_pos
);
  import bse_pkg::*;

  logic [WORD_BITS:0]   below_lo;
  logic [WORD_BITS:0]   below_hi;
  logic [WORD_BITS-1:0] live;
  logic [WORD_BITS-1:0] one_hot;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] iso;

  // search window: bits at or above lo_off and below hi_off
  assign below_lo = ~({(WORD_BITS+1){1'b1}} << lo_off);
  assign below_hi = ~({(WORD_BITS+1){1'b1}} << hi_off);
  assign live     = below_hi[WORD_BITS-1:0] & ~below_lo[WORD_BITS-1:0];

  // single bit for set / clear, lo_off is the offset within the word
  assign one_hot = {{(WORD_BITS-1){1'b0}}, 1'b1} << lo_off;

  // word update
  always_comb begin
    case (op)
      CMD_SET_BIT:  wr_word = t_word | one_hot;
      CMD_CLR_BIT:  wr_word = t_word & ~one_hot;
      CMD_UNION:    wr_word = t_word | s_word;
      CMD_COPY:     wr_word = s_word;
      CMD_SUBTRACT: wr_word = t_word & ~s_word;
      CMD_CLR_ALL:  wr_word = '0;
      CMD_SET_ALL:  wr_word = '1;
      default:      wr_word = t_word;
    endcase
  end

  assign words_eq = (t_word == s_word);

  // lowest set bit inside the window
  assign cand = t_word & live;
  assign iso  = cand & (~cand + WORD_BITS'(1));
  assign hit  = |cand;

  always_comb begin
    hit_pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) begin
        hit_pos = hit_pos | SW'(j);
      end
    end
  end

endmodule

// File: hdl/bitset_store_engine_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake    payload
// in_bus    in   valid/ready  command, target_set, source_set, bit_index
// out_bus   out  valid/ready  flag, found_index
// cfg_bus   in   valid/ready  bits_in_use (ready always high)
//
// Per word a read state fetches both sets, then the exec state updates,
// compares or searches and writes. Set-wide commands walk all words in use;
// set/clear and find skip words below bit_index with the read state alone.
// Bad commands go straight to the done state. Reset: a clearing pass writes
// zero to all words (64 at default) with in_bus.ready low. A waiting result
// stalls only a finished command.
module bitset_store_engine_core #(
  parameter int NUM_SETS  = 16,
  parameter int SET_BITS  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bse_in_if.sink    in_bus,
  bse_out_if.source out_bus,
  bse_cfg_if.sink   cfg_bus
);
  import bse_pkg::*;

  localparam int WPS   = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH = NUM_SETS * WPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW    = $clog2(WORD_BITS + 1);
  localparam int SW    = $clog2(WORD_BITS);
  localparam int BW    = $clog2(SET_BITS + WORD_BITS + 1);
  localparam int CW    = (BW > CFG_W) ? BW : CFG_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [CFG_W-1:0]     cfg_bits_r, cfg_bits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_flag_r, out_flag_nxt;
  logic [FOUND_W-1:0]   out_found_r, out_found_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [CW-1:0]        bit_r, bit_nxt;
  logic [CW-1:0]        base_r, base_nxt;
  logic [AW-1:0]        addr_t_r, addr_t_nxt;
  logic [AW-1:0]        addr_s_r, addr_s_nxt;
  logic                 flag_r, flag_nxt;
  logic [FOUND_W-1:0]   found_r, found_nxt;

  logic [CW-1:0]        lim;
  logic                 in_src_used;
  logic                 in_cmd_ok;
  logic [SET_IDX_W-1:0] in_src_eff;
  logic                 skip_word;
  logic [CW-1:0]        diff_lo;
  logic [CW-1:0]        diff_hi;
  logic [OW-1:0]        lo_off;
  logic [OW-1:0]        hi_off;
  logic                 exec_we;
  logic                 ram_we;
  logic [AW-1:0]        ram_wa;
  logic [WORD_BITS-1:0] ram_wd;
  logic [WORD_BITS-1:0] t_word;
  logic [WORD_BITS-1:0] s_word;
  logic [WORD_BITS-1:0] alu_word;
  logic                 words_eq;
  logic                 hit;
  logic [SW-1:0]        hit_pos;

  // valid bit count, clamped to the storage
  assign lim = (CW'(cfg_bits_r) > CW'(SET_BITS)) ? CW'(SET_BITS) : CW'(cfg_bits_r);

  // command decode at the input
  assign in_src_used = (in_bus.command >= CMD_UNION) && (in_bus.command <= CMD_EQUAL);
  assign in_cmd_ok   = (in_bus.command <= CMD_FIND) && (32'(in_bus.target_set) < NUM_SETS) &&
                       !(in_src_used && (32'(in_bus.source_set) >= NUM_SETS));
  assign in_src_eff  = in_src_used ? in_bus.source_set : in_bus.target_set;

  // current word lies wholly below bit_r
  assign skip_word = (bit_r >= base_r) && ((bit_r - base_r) >= CW'(WORD_BITS));

  // window offsets within the current word
  assign diff_lo = bit_r - base_r;
  assign diff_hi = lim - base_r;
  assign lo_off  = (bit_r <= base_r) ? '0 :
                   ((diff_lo >= CW'(WORD_BITS)) ? OW'(WORD_BITS) : OW'(diff_lo));
  assign hi_off  = (lim <= base_r) ? '0 :
                   ((diff_hi >= CW'(WORD_BITS)) ? OW'(WORD_BITS) : OW'(diff_hi));

  // store write mux: clearing pass or word update
  assign ram_we = (state_r == S_CLEAR) || exec_we;
  assign ram_wa = (state_r == S_CLEAR) ? clr_r : addr_t_r;
  assign ram_wd = (state_r == S_CLEAR) ? '0 : alu_word;

  bse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_wa),
    .wr_data   (ram_wd),
    .rd_addr_a (addr_t_r),
    .rd_data_a (t_word),
    .rd_addr_b (addr_s_r),
    .rd_data_b (s_word)
  );

  bse_word_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .op       (cmd_r),
    .t_word   (t_word),
    .s_word   (s_word),
    .lo_off   (lo_off),
    .hi_off   (hi_off),
    .wr_word  (alu_word),
    .words_eq (words_eq),
    .hit      (hit),
    .hit_pos  (hit_pos)
  );

  // handshakes
  assign in_bus.ready        = (state_r == S_IDLE);
  assign cfg_bus.ready       = 1'b1;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.flag        = out_flag_r;
  assign out_bus.found_index = out_found_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cfg_bits_nxt  = cfg_bus.valid ? cfg_bus.bits_in_use : cfg_bits_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_flag_nxt  = out_flag_r;
    out_found_nxt = out_found_r;
    cmd_nxt       = cmd_r;
    bit_nxt       = bit_r;
    base_nxt      = base_r;
    addr_t_nxt    = addr_t_r;
    addr_s_nxt    = addr_s_r;
    flag_nxt      = flag_r;
    found_nxt     = found_r;
    exec_we       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_bus.valid) begin
          cmd_nxt    = cmd_t'(in_bus.command);
          bit_nxt    = CW'(in_bus.bit_index);
          base_nxt   = '0;
          addr_t_nxt = AW'(32'(in_bus.target_set) * WPS);
          addr_s_nxt = AW'(32'(in_src_eff) * WPS);
          flag_nxt   = in_cmd_ok && (in_bus.command == CMD_EQUAL);
          found_nxt  = '0;
          state_nxt  = in_cmd_ok ? S_READ : S_DONE;
        end
      end

      // decide on the current word, issue the reads
      S_READ: begin
        case (cmd_r)
          CMD_SET_BIT, CMD_CLR_BIT: begin
            if (bit_r >= CW'(SET_BITS)) begin
              state_nxt = S_DONE;
            end else if (skip_word) begin
              base_nxt   = base_r + CW'(WORD_BITS);
              addr_t_nxt = addr_t_r + AW'(1);
              addr_s_nxt = addr_s_r + AW'(1);
            end else begin
              state_nxt = S_EXEC;
            end
          end
          CMD_FIND: begin
            if ((base_r >= lim) || (bit_r >= lim)) begin
              state_nxt = S_DONE;
            end else if (skip_word) begin
              base_nxt   = base_r + CW'(WORD_BITS);
              addr_t_nxt = addr_t_r + AW'(1);
              addr_s_nxt = addr_s_r + AW'(1);
            end else begin
              state_nxt = S_EXEC;
            end
          end
          default: begin
            state_nxt = (base_r >= lim) ? S_DONE : S_EXEC;
          end
        endcase
      end

      // word data present: update, compare or search
      S_EXEC: begin
        case (cmd_r)
          CMD_SET_BIT, CMD_CLR_BIT: begin
            exec_we   = 1'b1;
            state_nxt = S_DONE;
          end
          CMD_EQUAL: begin
            flag_nxt   = flag_r & words_eq;
            base_nxt   = base_r + CW'(WORD_BITS);
            addr_t_nxt = addr_t_r + AW'(1);
            addr_s_nxt = addr_s_r + AW'(1);
            state_nxt  = S_READ;
          end
          CMD_FIND: begin
            if (hit) begin
              flag_nxt  = 1'b1;
              found_nxt = FOUND_W'(base_r + CW'(hit_pos));
              state_nxt = S_DONE;
            end else begin
              base_nxt   = base_r + CW'(WORD_BITS);
              addr_t_nxt = addr_t_r + AW'(1);
              addr_s_nxt = addr_s_r + AW'(1);
              state_nxt  = S_READ;
            end
          end
          default: begin
            exec_we    = 1'b1;
            base_nxt   = base_r + CW'(WORD_BITS);
            addr_t_nxt = addr_t_r + AW'(1);
            addr_s_nxt = addr_s_r + AW'(1);
            state_nxt  = S_READ;
          end
        endcase
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cfg_bits_r  <= BITS_IN_USE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cfg_bits_r  <= cfg_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_flag_r  <= out_flag_nxt;
    out_found_r <= out_found_nxt;
    cmd_r       <= cmd_nxt;
    bit_r       <= bit_nxt;
    base_r      <= base_nxt;
    addr_t_r    <= addr_t_nxt;
    addr_s_r    <= addr_s_nxt;
    flag_r      <= flag_nxt;
    found_r     <= found_nxt;
  end

`ifndef SYNTHESIS
  // store is written only by the clearing pass or a word update
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_EXEC))
    else $error("store written outside clear or update phase");

  // a new result appears only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished command");

  // a found bit lies below the bits in use
  a_find_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_flag_r && cmd_r == CMD_FIND) |-> (CW'(out_found_r) < lim))
    else $error("find result beyond bits in use");
`endif

endmodule
